// ===== rtl/complex_fixed_point_alu_top_assert.svh =====
// Assertion macros used by complex_fixed_point_alu_top.sv, the RTL file that carries checks.
`ifndef COMPLEX_FIXED_POINT_ALU_TOP_ASSERT_SVH
`define COMPLEX_FIXED_POINT_ALU_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CFPA_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cfpa assertion failed");
`define CFPA_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("cfpa assertion failed");
`else
`define CFPA_ASSERT(label, prop)
`define CFPA_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/cfpa_pkg.sv =====
`timescale 1ns / 1ps

package cfpa_pkg;

  localparam int INT_WIDTH  = 7;
  localparam int FRAC_WIDTH = 8;
  localparam int WORD_W     = INT_WIDTH + FRAC_WIDTH + 1;

  // Port field widths.
  localparam int DATA_W = 16;
  localparam int KIND_W = 3;
  localparam int OV_W   = 2;
  localparam int CNT_W  = 32;

  localparam int IN_TDATA_W  = 4 * DATA_W;
  localparam int OUT_FIELD_W = 2 * DATA_W + OV_W + CNT_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [KIND_W-1:0] kind_t;

  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  localparam kind_t KIND_ADD   = 3'd0;
  localparam kind_t KIND_SUB   = 3'd1;
  localparam kind_t KIND_MUL   = 3'd2;
  localparam kind_t KIND_CONJ  = 3'd3;
  localparam kind_t KIND_SHIFT = 3'd4;
  localparam kind_t KIND_CLEAR = 3'd5;

  typedef struct packed {
    word_t val;
    logic  ov;
  } sum_t;

  // Wrapping add; an overflow is also flagged when two negatives land on the
  // most negative word.
  function automatic sum_t word_add(word_t x, word_t y);
    sum_t s;
    logic sx;
    logic sy;
    s.val = x + y;
    sx    = x[WORD_W-1];
    sy    = y[WORD_W-1];
    s.ov  = ((sx == sy) && (s.val[WORD_W-1] != sx)) ||
            ((sx == sy) && sx && (s.val == WORD_MIN));
    return s;
  endfunction

  function automatic sum_t word_sub(word_t x, word_t y);
    sum_t s;
    logic sx;
    logic sy;
    s.val = x - y;
    sx    = x[WORD_W-1];
    sy    = y[WORD_W-1];
    s.ov  = ((sx != sy) && (s.val[WORD_W-1] != sx)) ||
            ((sx != sy) && sx && (s.val == WORD_MIN));
    return s;
  endfunction

  function automatic word_t word_asr(word_t x);
    return {x[WORD_W-1], x[WORD_W-1:1]};
  endfunction

  function automatic word_t word_conj(word_t x);
    return (x == WORD_MIN) ? '0 : word_t'(-x);
  endfunction

endpackage

// ===== rtl/cfpa_word_mul.sv =====
`timescale 1ns / 1ps

// Fixed-point product with the results of a W-bit wrapping radix-2 Booth
// accumulator. For any multiplicand other than the most negative word the
// accumulator never wraps, so the exact product gives the same bits. For the
// most negative multiplicand every add or subtract only toggles the sign bit,
// which leaves the multiplier itself in the accumulator and zeros below it.
module cfpa_word_mul import cfpa_pkg::*; (
  input  word_t x,
  input  word_t y,
  output word_t r
);

  logic signed [2*WORD_W-1:0] prod;
  logic        [2*WORD_W-2:0] full;

  assign prod = $signed(x) * $signed(y);

  always_comb begin
    if (x == WORD_MIN) begin
      full = {y, {(WORD_W-1){1'b0}}};
    end else begin
      full = prod[2*WORD_W-2:0];
    end
  end

  // The sign bit of the result is the top bit of the accumulator.
  assign r = {full[2*WORD_W-2], full[FRAC_WIDTH+WORD_W-2:FRAC_WIDTH]};

endmodule

// ===== rtl/complex_fixed_point_alu_top.sv =====
// A result passes through the input register, then the result register,
// and is held in the result register while out_tready is low.
// Throughput: one item per cycle while out_tready is high; the four multipliers and the add/subtract
// stage all sit between the input register and the result register.
// Reset (rst_n low, synchronous): both valid flags and the overflow count clear.
`timescale 1ns / 1ps
`include "complex_fixed_point_alu_top_assert.svh"

module complex_fixed_point_alu_top import cfpa_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // a_re, a_im, b_re, b_im
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // kind
  input  logic [KIND_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // res_re, res_im, op_overflows, overflow_total, zero padding
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic       s1_valid_r;
  kind_t      s1_kind_r;
  word_t      s1_ar_r;
  word_t      s1_ai_r;
  word_t      s1_br_r;
  word_t      s1_bi_r;

  logic       out_valid_r;
  word_t      out_re_r;
  word_t      out_im_r;
  logic [OV_W-1:0]  out_ov_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W:0]   cnt_sum;

  logic       out_free;
  logic       s1_move;
  logic       in_xfer;

  word_t      p_rr;
  word_t      p_ii;
  word_t      p_ri;
  word_t      p_ir;
  sum_t       sum_re;
  sum_t       sum_im;
  logic [OV_W-1:0] ov_sum;

  assign out_free  = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_xfer   = in_tvalid && in_tready;

  cfpa_word_mul u_mul_rr (.x(s1_ar_r), .y(s1_br_r), .r(p_rr));
  cfpa_word_mul u_mul_ii (.x(s1_ai_r), .y(s1_bi_r), .r(p_ii));
  cfpa_word_mul u_mul_ri (.x(s1_ar_r), .y(s1_bi_r), .r(p_ri));
  cfpa_word_mul u_mul_ir (.x(s1_ai_r), .y(s1_br_r), .r(p_ir));

  always_comb begin
    sum_re = '0;
    sum_im = '0;
    unique case (s1_kind_r)
      KIND_ADD: begin
        sum_re = word_add(s1_ar_r, s1_br_r);
        sum_im = word_add(s1_ai_r, s1_bi_r);
      end
      KIND_SUB: begin
        sum_re = word_sub(s1_ar_r, s1_br_r);
        sum_im = word_sub(s1_ai_r, s1_bi_r);
      end
      KIND_MUL: begin
        sum_re = word_sub(p_rr, p_ii);
        sum_im = word_add(p_ri, p_ir);
      end
      KIND_CONJ: begin
        sum_re.val = s1_ar_r;
        sum_im.val = word_conj(s1_ai_r);
      end
      KIND_SHIFT: begin
        sum_re.val = word_asr(s1_ar_r);
        sum_im.val = word_asr(s1_ai_r);
      end
      default: begin
        sum_re = '0;
        sum_im = '0;
      end
    endcase
  end

  assign ov_sum  = {1'b0, sum_re.ov} + {1'b0, sum_im.ov};
  assign cnt_sum = {1'b0, cnt_r} + {{(CNT_W+1-OV_W){1'b0}}, ov_sum};

  // The count clears on a clear item and otherwise saturates at all ones.
  always_comb begin
    if (s1_kind_r == KIND_CLEAR) begin
      cnt_nxt = '0;
    end else if (cnt_sum[CNT_W]) begin
      cnt_nxt = '1;
    end else begin
      cnt_nxt = cnt_sum[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r <= in_tuser;
      s1_ar_r   <= in_tdata[0*DATA_W +: WORD_W];
      s1_ai_r   <= in_tdata[1*DATA_W +: WORD_W];
      s1_br_r   <= in_tdata[2*DATA_W +: WORD_W];
      s1_bi_r   <= in_tdata[3*DATA_W +: WORD_W];
    end
    if (s1_move) begin
      out_re_r <= sum_re.val;
      out_im_r <= sum_im.val;
      out_ov_r <= ov_sum;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, cnt_r, out_ov_r,
                       DATA_W'(out_im_r), DATA_W'(out_re_r)};

  // The count only falls when a clear item has just moved to the output.
  `CFPA_ASSERT(a_cnt_no_drop, (cnt_r < $past(cnt_r)) |-> $past(s1_move && (s1_kind_r == KIND_CLEAR)))
  // A result that reports overflows cannot come with a zero running total.
  `CFPA_ASSERT(a_ov_counted, (out_valid_r && (out_ov_r != '0)) |-> (cnt_r != '0))
  // An accepted item is held in the input register on the next cycle.
  `CFPA_ASSERT(a_in_held, in_xfer |=> s1_valid_r)
  // Coming out of reset the pipeline is empty and the count is zero.
  `CFPA_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (!s1_valid_r && !out_valid_r && (cnt_r == '0)))

endmodule
